### rtl/wildcard_code_signature_scanner_macros.svh
// Assertion macros for the signature scanner.
// Used by files that assert; expects clk and rst_n in scope.
`ifndef WILDCARD_CODE_SIGNATURE_SCANNER_MACROS_SVH
`define WILDCARD_CODE_SIGNATURE_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WCSS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define WCSS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WCSS_ASSERT_NOW(name, ante, cons, msg)
`define WCSS_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

### rtl/wcss_pkg.sv
// Shared constants and types of the signature scanner.
// No dependencies.
package wcss_pkg;

  localparam int MAX_SECTIONS  = 96;
  localparam int SEC_IDX_W     = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int SEC_CNT_W     = $clog2(MAX_SECTIONS + 1);
  localparam int PATTERN_BYTES = 37;
  localparam int WINDOW_DEPTH  = PATTERN_BYTES - 1;
  localparam int ID_BYTES      = 16;
  localparam int NUM_ADDRS     = 4;

  localparam logic CMD_SECTION = 1'b0;
  localparam logic CMD_BYTE    = 1'b1;

  // instruction sequence; wildcard bytes hold zero and are not cared for
  localparam logic [7:0] SIG_VALUE [PATTERN_BYTES] = '{
    8'h8B, 8'h0D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h89, 8'h08,
    8'h8B, 8'h15, 8'h00, 8'h00, 8'h00, 8'h00, 8'h89, 8'h50, 8'h04,
    8'h8B, 8'h0D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h89, 8'h48, 8'h08,
    8'h8B, 8'h15, 8'h00, 8'h00, 8'h00, 8'h00, 8'h89, 8'h50, 8'h0C,
    8'h33, 8'hC0
  };

  localparam logic SIG_CARE [PATTERN_BYTES] = '{
    1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
    1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
    1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
    1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
    1'b1, 1'b1
  };

  // byte offset of each little-endian address operand in the window
  localparam int ADDR_AT [NUM_ADDRS] = '{2, 10, 19, 28};

  typedef struct packed {
    logic [31:0] raw_size;
    logic [31:0] raw_offset;
    logic [31:0] virt_size;
    logic [31:0] virt_base;
  } sec_entry_t;

  localparam int SEC_ENTRY_W = $bits(sec_entry_t);

  typedef struct packed {
    logic        sub;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] cmp;
  } alu_req_t;

  typedef struct packed {
    logic [32:0] res;   // sum, or for sub: bit 32 set when a >= b
    logic        eq;    // res[31:0] == cmp
    logic        lt;    // res < cmp
    logic        le;    // res <= cmp
  } alu_rsp_t;

endpackage

### rtl/wildcard_code_signature_scanner.sv
// Sequence: a section load is written to the section RAM from idle; a byte that is no
// candidate stops at the fixed-byte or operand checks; a candidate walks the sections in
// use up to the first fit, checks room for the string when one fits, then waits in
// S_EMIT while the result register is full. One item at a time: in_tready is low while
// the sequencer checks a byte or walks the table via the shared adder and RAM read port.
// Reset (rst_n, synchronous): window, position, registers and output valid clear;
module wildcard_code_signature_scanner (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // [7:0] data_byte, [14:8] entry_index, [46:15] entry_virtual_base,
  // [78:47] entry_virtual_size, [110:79] entry_file_offset,
  // [142:111] entry_file_size, [143] zero
  input  logic [143:0] in_tdata,
  input  logic         in_tuser,   // [0] command
  input  logic         in_tlast,   // last_byte
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] match_position, [63:32] string_address, [64] mapped,
  // [96:65] mapped_offset, [103:97] zero
  output logic [103:0] out_tdata,
  // configuration
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  // section table contents stay undefined until loaded.

`include "wildcard_code_signature_scanner_macros.svh"

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SIG  = 4'd1;  // fixed bytes, a1 == a0+4
  localparam logic [3:0] S_ADR2 = 4'd2;  // a2 == a0+8
  localparam logic [3:0] S_ADR3 = 4'd3;  // a3 == a0+12
  localparam logic [3:0] S_RD   = 4'd4;  // section RAM read in flight
  localparam logic [3:0] S_DIFF = 4'd5;  // d = a0 - base
  localparam logic [3:0] S_FIT  = 4'd6;  // bounds, offset = raw + d
  localparam logic [3:0] S_ROOM = 4'd7;  // offset + ID_BYTES within image
  localparam logic [3:0] S_EMIT = 4'd8;  // wait for result register

  // register index (byte address bit 2)
  localparam logic REG_SECTIONS  = 1'b0;
  localparam logic REG_IMAGE_LEN = 1'b1;

  logic [3:0]  state_r, state_nxt;

  // config registers
  logic [6:0]  sec_use_r;
  logic [31:0] image_len_r;
  logic        cfg_wr;

  // input fields
  logic [7:0]  f_byte;
  logic [6:0]  f_index;
  wcss_pkg::sec_entry_t f_entry;

  logic        in_xfer, byte_xfer, sec_xfer;
  logic        finish;

  // item context
  logic [31:0] pos_r;
  logic [31:0] mpos_r;
  logic        elig_r;
  logic        last_r;

  // walk state
  logic [wcss_pkg::SEC_IDX_W-1:0] idx_r;
  logic [wcss_pkg::SEC_CNT_W-1:0] sec_cnt;
  logic        idx_last;
  logic [31:0] d_r;
  logic        ge_r;
  logic [31:0] off_r;
  logic        mapped_r;

  // result register
  logic        out_valid_r;
  logic [31:0] out_mpos_r;
  logic [31:0] out_addr_r;
  logic        out_mapped_r;
  logic [31:0] out_moff_r;
  logic        out_load;

  logic        sig_ok;
  logic [wcss_pkg::NUM_ADDRS-1:0][31:0] words;

  wcss_pkg::sec_entry_t sec_rd;
  logic [wcss_pkg::SEC_ENTRY_W-1:0] sec_rd_bits;
  wcss_pkg::alu_req_t alu_req;
  wcss_pkg::alu_rsp_t alu_rsp;
  logic        fit;

  // ---------------------------------------------------------------- ports
  assign f_byte               = in_tdata[7:0];
  assign f_index              = in_tdata[14:8];
  assign f_entry.virt_base    = in_tdata[46:15];
  assign f_entry.virt_size    = in_tdata[78:47];
  assign f_entry.raw_offset   = in_tdata[110:79];
  assign f_entry.raw_size     = in_tdata[142:111];

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign byte_xfer = in_xfer && (in_tuser == wcss_pkg::CMD_BYTE);
  // out-of-range slots are dropped
  assign sec_xfer  = in_xfer && (in_tuser == wcss_pkg::CMD_SECTION)
                     && (32'(f_index) < 32'(wcss_pkg::MAX_SECTIONS));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_moff_r, out_mapped_r, out_addr_r, out_mpos_r};

  // ---------------------------------------------------------------- config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_use_r   <= 7'd0;
      image_len_r <= 32'd0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_SECTIONS:  sec_use_r   <= cfg_pwdata[6:0];
        REG_IMAGE_LEN: image_len_r <= cfg_pwdata;
        default:       sec_use_r   <= sec_use_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_SECTIONS:  cfg_prdata = {25'd0, sec_use_r};
      REG_IMAGE_LEN: cfg_prdata = image_len_r;
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // sections searched, capped at the table depth
  assign sec_cnt = (32'(sec_use_r) > 32'(wcss_pkg::MAX_SECTIONS))
                   ? wcss_pkg::SEC_CNT_W'(wcss_pkg::MAX_SECTIONS)
                   : wcss_pkg::SEC_CNT_W'(sec_use_r);
  assign idx_last = ((wcss_pkg::SEC_CNT_W'(idx_r) + 1'b1) == sec_cnt);

  // ---------------------------------------------------------------- datapath units
  // window shifts on every byte transfer; a final byte clears it once its scan is done
  wcss_win u_win (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (byte_xfer),
    .clear    (finish && last_r),
    .din      (f_byte),
    .sig_ok   (sig_ok),
    .words    (words)
  );

  // section table; read address is the walk index, held while an entry is evaluated
  wcss_ram #(
    .WIDTH (wcss_pkg::SEC_ENTRY_W),
    .DEPTH (wcss_pkg::MAX_SECTIONS)
  ) u_sec_ram (
    .clk   (clk),
    .we    (sec_xfer),
    .waddr (wcss_pkg::SEC_IDX_W'(f_index)),
    .wdata (f_entry),
    .raddr (idx_r),
    .rdata (sec_rd_bits)
  );
  assign sec_rd = sec_rd_bits;

  // one adder serves the operand chain checks and the arithmetic steps of the section walk
  always_comb begin
    alu_req = '0;
    case (state_r)
      S_SIG: begin
        alu_req.a   = words[0];
        alu_req.b   = 32'd4;
        alu_req.cmp = words[1];
      end
      S_ADR2: begin
        alu_req.a   = words[0];
        alu_req.b   = 32'd8;
        alu_req.cmp = words[2];
      end
      S_ADR3: begin
        alu_req.a   = words[0];
        alu_req.b   = 32'd12;
        alu_req.cmp = words[3];
      end
      S_DIFF: begin
        alu_req.sub = 1'b1;
        alu_req.a   = words[0];
        alu_req.b   = sec_rd.virt_base;
      end
      S_FIT: begin
        alu_req.a   = sec_rd.raw_offset;
        alu_req.b   = d_r;
        alu_req.cmp = image_len_r;
      end
      S_ROOM: begin
        alu_req.a   = off_r;
        alu_req.b   = 32'(wcss_pkg::ID_BYTES);
        alu_req.cmp = image_len_r;
      end
      default: alu_req = '0;
    endcase
  end

  wcss_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // first fitting section: inside both sizes and raw offset + d inside the image
  assign fit = ge_r && (d_r < sec_rd.virt_size) && (d_r < sec_rd.raw_size) && alu_rsp.lt;

  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    finish    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (byte_xfer) begin
          state_nxt = S_SIG;
        end
      end
      S_SIG: begin
        if (elig_r && sig_ok && alu_rsp.eq) begin
          state_nxt = S_ADR2;
        end else begin
          state_nxt = S_IDLE;
          finish    = 1'b1;
        end
      end
      S_ADR2: begin
        if (alu_rsp.eq) begin
          state_nxt = S_ADR3;
        end else begin
          state_nxt = S_IDLE;
          finish    = 1'b1;
        end
      end
      S_ADR3: begin
        if (!alu_rsp.eq) begin
          state_nxt = S_IDLE;
          finish    = 1'b1;
        end else if (sec_cnt == '0) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD:   state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_FIT;
      S_FIT: begin
        if (fit) begin
          state_nxt = S_ROOM;
        end else if (idx_last) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_ROOM: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
          finish    = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        finish    = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= 32'd0;
      last_r  <= 1'b0;
      elig_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (byte_xfer) begin
        elig_r <= (pos_r >= 32'(wcss_pkg::WINDOW_DEPTH));
        last_r <= in_tlast;
        pos_r  <= in_tlast ? 32'd0 : pos_r + 32'd1;
      end
    end
  end

  // item context and walk registers
  always_ff @(posedge clk) begin
    if (byte_xfer) begin
      mpos_r <= pos_r - 32'(wcss_pkg::WINDOW_DEPTH);
    end
    case (state_r)
      S_ADR3: begin
        idx_r    <= '0;
        mapped_r <= 1'b0;
      end
      S_DIFF: begin
        d_r  <= alu_rsp.res[31:0];
        ge_r <= alu_rsp.res[32];
      end
      S_FIT: begin
        if (fit) begin
          off_r <= alu_rsp.res[31:0];
        end else if (!idx_last) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      S_ROOM:  mapped_r <= alu_rsp.le;
      default: idx_r    <= idx_r;
    endcase
  end

  // result register: takes a new result while the consumer drains the old one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mpos_r   <= mpos_r;
      out_addr_r   <= words[0];
      out_mapped_r <= mapped_r;
      out_moff_r   <= mapped_r ? off_r : 32'd0;
    end
  end

  // ---------------------------------------------------------------- checks
  `WCSS_ASSERT_NOW(a_idx_in_range, (state_r == S_DIFF || state_r == S_FIT), (wcss_pkg::SEC_CNT_W'(idx_r) < sec_cnt), "walk index past sections in use")
  `WCSS_ASSERT_NOW(a_room_in_image, (state_r == S_ROOM), (off_r < image_len_r), "mapped offset outside image")
  `WCSS_ASSERT_NOW(a_unmapped_zero, (out_valid_r && !out_mapped_r), (out_moff_r == 32'd0), "unmapped result with nonzero offset")
  `WCSS_ASSERT_NEXT(a_last_clears_pos, (byte_xfer && in_tlast), (pos_r == 32'd0), "position not cleared after final byte")
  `WCSS_ASSERT_NEXT(a_emit_holds, (state_r == S_EMIT && !out_load), (state_r == S_EMIT && out_valid_r), "result lost while output stalled")

endmodule

### rtl/wcss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wcss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### rtl/wcss_alu.sv
// Shared 32-bit add/subtract unit with compare against a third operand.
// Depends on wcss_pkg.
module wcss_alu (
  input  wcss_pkg::alu_req_t req,
  output wcss_pkg::alu_rsp_t rsp
);

  logic [32:0] sum;

  assign sum = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + {32'd0, req.sub};

  always_comb begin
    rsp.res = sum;
    rsp.eq  = (sum[31:0] == req.cmp);
    rsp.lt  = (sum < {1'b0, req.cmp});
    rsp.le  = (sum <= {1'b0, req.cmp});
  end

endmodule

### rtl/wcss_win.sv
// 37-byte window shift line, fixed-byte compare and address operand taps.
// Depends on wcss_pkg.
module wcss_win (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   shift_en,
  input  logic                                   clear,
  input  logic [7:0]                             din,
  output logic                                   sig_ok,
  output logic [wcss_pkg::NUM_ADDRS-1:0][31:0]   words
);

  logic [7:0] win_r [wcss_pkg::PATTERN_BYTES];

  // win_r[0] is the oldest byte, win_r[PATTERN_BYTES-1] the newest
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int k = 0; k < wcss_pkg::PATTERN_BYTES; k++) begin
        win_r[k] <= 8'h00;
      end
    end else if (shift_en) begin
      for (int k = 0; k < wcss_pkg::PATTERN_BYTES - 1; k++) begin
        win_r[k] <= win_r[k+1];
      end
      win_r[wcss_pkg::PATTERN_BYTES-1] <= din;
    end
  end

  always_comb begin
    sig_ok = 1'b1;
    for (int k = 0; k < wcss_pkg::PATTERN_BYTES; k++) begin
      if (wcss_pkg::SIG_CARE[k] && (win_r[k] != wcss_pkg::SIG_VALUE[k])) begin
        sig_ok = 1'b0;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < wcss_pkg::NUM_ADDRS; j++) begin
      words[j] = {win_r[wcss_pkg::ADDR_AT[j]+3], win_r[wcss_pkg::ADDR_AT[j]+2],
                  win_r[wcss_pkg::ADDR_AT[j]+1], win_r[wcss_pkg::ADDR_AT[j]]};
    end
  end

endmodule

### tb/wildcard_code_signature_scanner_tb.sv
// Self-checking testbench for wildcard_code_signature_scanner: streams section entries
// and image bytes, predicts every candidate hit and its file mapping, checks each result.
// Depends on wcss_pkg and the scanner RTL only.
`timescale 1ns / 100ps

module wildcard_code_signature_scanner_tb;

  // APB register map: register i at byte address 4*i
  localparam bit [2:0] REG_SECTIONS_IN_USE = 3'd0;
  localparam bit [2:0] REG_IMAGE_LENGTH    = 3'd4;

  // worst case of one candidate: fixed cost plus a walk over the whole table
  localparam int SETTLE_CYCLES  = 5 + 3 * wcss_pkg::MAX_SECTIONS + 16;
  localparam int CYCLE_LIMIT    = 3000000;
  localparam int RANDOM_ITEMS   = 300;
  localparam int BLOCK_ITEMS    = 160;   // items between register changes

  // shapes of a 37-byte instruction run
  typedef enum int {SEQ_GOOD, SEQ_BAD_ADDR, SEQ_BAD_OPCODE, SEQ_CUT} seq_kind_t;

  typedef struct packed {
    bit        cmd;
    bit        last;
    bit [6:0]  slot;
    bit [7:0]  data;
    bit [31:0] vbase;
    bit [31:0] vsize;
    bit [31:0] foff;
    bit [31:0] fsize;
  } scan_item_t;

  typedef struct packed {
    bit [31:0] position;
    bit [31:0] address;
    bit        mapped;
    bit [31:0] offset;
  } scan_hit_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // [7:0] data_byte, [14:8] entry_index, [46:15] entry_virtual_base,
  // [78:47] entry_virtual_size, [110:79] entry_file_offset,
  // [142:111] entry_file_size, [143] zero
  logic [143:0] in_tdata;
  logic         in_tuser;   // [0] command
  logic         in_tlast;   // last_byte
  logic         out_tvalid;
  logic         out_tready;
  // [31:0] match_position, [63:32] string_address, [64] mapped,
  // [96:65] mapped_offset, [103:97] zero
  logic [103:0] out_tdata;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  wildcard_code_signature_scanner uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the scanner: registers, byte window, position and section table
  // ---------------------------------------------------------------------------
  bit [6:0]  sec_count_reg;
  bit [31:0] image_len_reg;
  bit [7:0]  win_hist [wcss_pkg::WINDOW_DEPTH];   // oldest byte first
  bit [31:0] stream_pos;
  bit [31:0] sec_vbase [wcss_pkg::MAX_SECTIONS];
  bit [31:0] sec_vsize [wcss_pkg::MAX_SECTIONS];
  bit [31:0] sec_roff  [wcss_pkg::MAX_SECTIONS];
  bit [31:0] sec_rsize [wcss_pkg::MAX_SECTIONS];

  scan_hit_t expected_hits [$];   // predicted results, oldest first
  scan_hit_t oldest_hit;
  int        mismatch_count;
  int        cycle_count;
  bit        gaps_on;    // sender may pause between transfers
  bit        stall_on;   // receiver may hold off out_tready

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  // First section that holds addr wins. Offset sum is kept exact (33 bits),
  // so a raw offset near the top of the range never wraps into the image.
  function automatic bit map_string(input bit [31:0] addr, output bit [32:0] off);
    int        lim;
    bit [31:0] d;
    bit [32:0] o;
    lim = (int'(sec_count_reg) > wcss_pkg::MAX_SECTIONS) ? wcss_pkg::MAX_SECTIONS
                                                         : int'(sec_count_reg);
    off = '0;
    for (int i = 0; i < lim; i++) begin
      if (addr < sec_vbase[i]) continue;
      d = addr - sec_vbase[i];
      if (d >= sec_vsize[i] || d >= sec_rsize[i]) continue;
      o = {1'b0, sec_roff[i]} + {1'b0, d};
      if (o >= {1'b0, image_len_reg}) continue;
      off = o;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one accepted transfer to the shadow; returns 1 when it yields a result.
  function automatic bit predict_scan(input scan_item_t it, output scan_hit_t hit);
    bit [7:0]  w [wcss_pkg::PATTERN_BYTES];
    bit [31:0] a [wcss_pkg::NUM_ADDRS];
    bit        found;
    bit        ok;
    bit [32:0] off;
    found = 1'b0;
    hit   = '0;
    if (it.cmd == wcss_pkg::CMD_SECTION) begin
      // slots past the table are dropped
      if (it.slot < wcss_pkg::MAX_SECTIONS) begin
        sec_vbase[it.slot] = it.vbase;
        sec_vsize[it.slot] = it.vsize;
        sec_roff[it.slot]  = it.foff;
        sec_rsize[it.slot] = it.fsize;
      end
      return 1'b0;
    end
    for (int k = 0; k < wcss_pkg::WINDOW_DEPTH; k++) w[k] = win_hist[k];
    w[wcss_pkg::WINDOW_DEPTH] = it.data;
    // window only counts once 36 bytes precede the current one
    if (stream_pos >= wcss_pkg::WINDOW_DEPTH) begin
      found = 1'b1;
      for (int k = 0; k < wcss_pkg::PATTERN_BYTES; k++)
        if (wcss_pkg::SIG_CARE[k] && w[k] != wcss_pkg::SIG_VALUE[k]) found = 1'b0;
      for (int j = 0; j < wcss_pkg::NUM_ADDRS; j++)
        a[j] = {w[wcss_pkg::ADDR_AT[j] + 3], w[wcss_pkg::ADDR_AT[j] + 2],
                w[wcss_pkg::ADDR_AT[j] + 1], w[wcss_pkg::ADDR_AT[j]]};
      // operands must be consecutive dwords, mod 2^32
      if (found && a[1] == a[0] + 32'd4 && a[2] == a[0] + 32'd8 && a[3] == a[0] + 32'd12)
      begin
        ok = map_string(a[0], off);
        // room for the identifier string behind the mapped offset
        if (ok && ({1'b0, off} + 34'(wcss_pkg::ID_BYTES)) > {2'b0, image_len_reg}) ok = 1'b0;
        hit.position = stream_pos - 32'(wcss_pkg::WINDOW_DEPTH);
        hit.address  = a[0];
        hit.mapped   = ok;
        hit.offset   = ok ? off[31:0] : 32'd0;
      end else begin
        found = 1'b0;
      end
    end
    if (it.last) begin
      for (int k = 0; k < wcss_pkg::WINDOW_DEPTH; k++) win_hist[k] = 8'd0;
      stream_pos = 32'd0;
    end else begin
      for (int k = 0; k < wcss_pkg::WINDOW_DEPTH; k++) win_hist[k] = w[k + 1];
      stream_pos = stream_pos + 32'd1;
    end
    return found;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // all fields random, then the caller fixes the ones that matter
  function automatic scan_item_t random_item();
    scan_item_t it;
    it.cmd   = 1'($urandom_range(0, 1));
    it.last  = 1'($urandom_range(0, 1));
    it.slot  = 7'($urandom_range(0, 127));
    it.data  = 8'($urandom_range(0, 255));
    it.vbase = $urandom;
    it.vsize = $urandom;
    it.foff  = $urandom;
    it.fsize = $urandom;
    return it;
  endfunction

  function automatic scan_item_t byte_item(input bit [7:0] b, input bit last);
    scan_item_t it;
    it      = random_item();
    it.cmd  = wcss_pkg::CMD_BYTE;
    it.data = b;
    it.last = last;
    return it;
  endfunction

  function automatic scan_item_t section_item(input bit [6:0] slot, input bit [31:0] vb,
                                              input bit [31:0] vs, input bit [31:0] fo,
                                              input bit [31:0] fs);
    scan_item_t it;
    it       = random_item();
    it.cmd   = wcss_pkg::CMD_SECTION;
    it.slot  = slot;
    it.vbase = vb;
    it.vsize = vs;
    it.foff  = fo;
    it.fsize = fs;
    return it;
  endfunction

  // One transfer on the input stream; optional idle burst ahead of it.
  // Prediction runs at the accepting edge, well before any result can show up.
  task automatic send_item(input scan_item_t it);
    int        gap;
    scan_hit_t hit;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tlast  <= it.last;
    in_tdata  <= {1'b0, it.fsize, it.foff, it.vsize, it.vbase, it.slot, it.data};
    do @(posedge clk); while (!in_tready);
    if (predict_scan(it, hit)) begin
      expected_hits.push_back(hit);
    end
  endtask

  // Builds the instruction run around a0 and streams it. Broken variants corrupt
  // one operand, one opcode byte, or end the image in the middle of the run.
  task automatic send_signature(input bit [31:0] a0, input seq_kind_t kind, input bit close);
    bit [7:0]  seq [wcss_pkg::PATTERN_BYTES];
    bit [31:0] addr;
    int        bad_op;
    int        k;
    int        cut_at;
    bad_op = $urandom_range(1, wcss_pkg::NUM_ADDRS - 1);
    for (int i = 0; i < wcss_pkg::PATTERN_BYTES; i++) seq[i] = wcss_pkg::SIG_VALUE[i];
    for (int j = 0; j < wcss_pkg::NUM_ADDRS; j++) begin
      addr = a0 + 32'(4 * j);
      if (kind == SEQ_BAD_ADDR && j == bad_op) addr ^= 32'd1 << $urandom_range(0, 31);
      for (int b = 0; b < 4; b++) seq[wcss_pkg::ADDR_AT[j] + b] = addr[8 * b +: 8];
    end
    if (kind == SEQ_BAD_OPCODE) begin
      do k = $urandom_range(0, wcss_pkg::PATTERN_BYTES - 1); while (!wcss_pkg::SIG_CARE[k]);
      seq[k] ^= 8'd1 << $urandom_range(0, 7);
    end
    cut_at = (kind == SEQ_CUT) ? $urandom_range(0, wcss_pkg::PATTERN_BYTES - 2) : -1;
    for (int i = 0; i < wcss_pkg::PATTERN_BYTES; i++)
      send_item(byte_item(seq[i], (i == cut_at)
                                  || (close && i == wcss_pkg::PATTERN_BYTES - 1)));
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++)
      send_item(byte_item(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0));
  endtask

  // plausible section layout most of the time, raw 32-bit values otherwise
  task automatic load_random_slot(input bit [6:0] slot);
    bit [31:0] vb;
    bit [31:0] vs;
    bit [31:0] fo;
    bit [31:0] fs;
    vb = ($urandom_range(0, 3) == 0) ? $urandom : 32'h0040_0000 + ($urandom_range(0, 255) << 12);
    vs = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h2_0000);
    fo = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h3_0000);
    fs = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h2_0000);
    send_item(section_item(slot, vb, vs, fo, fs));
  endtask

  // Sender goes quiet until every predicted result is out, then gives the
  // section walk time to finish before registers may change.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register
  task automatic set_reg(input bit [2:0] addr, input bit [31:0] value);
    bit [31:0] readback;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == REG_SECTIONS_IN_USE) sec_count_reg = value[6:0];
    else image_len_reg = value;
    readback = (addr == REG_SECTIONS_IN_USE) ? {25'd0, sec_count_reg} : image_len_reg;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== readback) begin
      $error("prdata @%0d: expected %h, got %h", addr, readback, cfg_prdata);
      mismatch_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // candidate address: mostly at or next to the edges of a live section
  function automatic bit [31:0] pick_string_address();
    int        lim;
    int        s;
    bit [31:0] span;
    lim = (int'(sec_count_reg) > wcss_pkg::MAX_SECTIONS) ? wcss_pkg::MAX_SECTIONS
                                                         : int'(sec_count_reg);
    if (lim == 0 || $urandom_range(0, 4) == 0) return $urandom;
    s    = $urandom_range(0, lim - 1);
    span = (sec_vsize[s] < sec_rsize[s]) ? sec_vsize[s] : sec_rsize[s];
    case ($urandom_range(0, 5))
      0:       return sec_vbase[s];
      1:       return sec_vbase[s] + span - 32'd1;
      2:       return sec_vbase[s] + span;
      3:       return sec_vbase[s] - 32'd1;
      default: return sec_vbase[s] + ((span == 0) ? 32'd0 : $urandom % span);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and in-order checking
  // ---------------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_hits.size() == 0) begin
        $error("unexpected result: match_position %h string_address %h",
               out_tdata[31:0], out_tdata[63:32]);
        mismatch_count++;
      end else begin
        oldest_hit = expected_hits.pop_front();
        if (out_tdata[31:0] !== oldest_hit.position) begin
          $error("match_position: expected %h, got %h", oldest_hit.position, out_tdata[31:0]);
          mismatch_count++;
        end
        if (out_tdata[63:32] !== oldest_hit.address) begin
          $error("string_address: expected %h, got %h", oldest_hit.address, out_tdata[63:32]);
          mismatch_count++;
        end
        if (out_tdata[64] !== oldest_hit.mapped) begin
          $error("mapped: expected %b, got %b", oldest_hit.mapped, out_tdata[64]);
          mismatch_count++;
        end
        if (out_tdata[96:65] !== oldest_hit.offset) begin
          $error("mapped_offset: expected %h, got %h", oldest_hit.offset, out_tdata[96:65]);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // register extremes and masking of the 7-bit count; ends with an empty table
  task automatic test_registers();
    set_reg(REG_SECTIONS_IN_USE, 32'd127);
    set_reg(REG_SECTIONS_IN_USE, 32'hFFFF_FF80);
    set_reg(REG_IMAGE_LENGTH, 32'hFFFF_FFFF);
    set_reg(REG_IMAGE_LENGTH, 32'd0);
    set_reg(REG_IMAGE_LENGTH, 32'h0001_0000);
  endtask

  // No sections loaded: candidates are still reported, never mapped.
  // Covers a run at stream offset 0, last byte closing a run, wrapping operands
  // and each broken shape.
  task automatic test_unmapped_candidates();
    send_signature(32'h0040_1000, SEQ_GOOD, 1'b0);
    send_noise(3);
    send_signature(32'hFFFF_FFF8, SEQ_GOOD, 1'b1);     // a2/a3 wrap past zero
    send_signature(32'h0000_0000, SEQ_GOOD, 1'b0);     // window restarts at zero
    send_signature(32'hFFFF_FFFF, SEQ_BAD_ADDR, 1'b0);
    send_signature(32'h0040_2000, SEQ_BAD_OPCODE, 1'b0);
    send_signature(32'h0040_3000, SEQ_CUT, 1'b0);
    send_signature(32'h1234_5678, SEQ_GOOD, 1'b1);
    settle();
  endtask

  // fill every slot before any count above zero, then poke past the table
  task automatic test_section_table();
    for (int i = 0; i < wcss_pkg::MAX_SECTIONS; i++) load_random_slot(7'(i));
    load_random_slot(7'd96);
    load_random_slot(7'd127);
    load_random_slot(7'($urandom_range(97, 126)));
    settle();
  endtask

  // Hand-built table: raw size shorter than virtual size, a fallback section,
  // a first fit without room for the string (no later section tried), and a
  // raw offset near 2^32 where the offset sum must not wrap.
  task automatic test_mapping();
    bit [31:0] short_len_probes [8] = '{32'h0040_1000, 32'h0040_17FF, 32'h0040_1800,
                                        32'h0040_0FFF, 32'h0040_FFF5, 32'h0041_0000,
                                        32'h0041_0020, 32'h003F_FFFF};
    bit [31:0] full_len_probes [5] = '{32'h0041_0000, 32'h0041_0020, 32'h0041_003F,
                                       32'h0041_0040, 32'h0041_0050};
    send_item(section_item(7'd0, 32'h0040_1000, 32'h0000_1000, 32'h0000_0400, 32'h0000_0800));
    send_item(section_item(7'd1, 32'h0040_0000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000));
    send_item(section_item(7'd2, 32'h0040_0000, 32'h0001_0020, 32'h0000_0000, 32'hFFFF_FFFF));
    send_item(section_item(7'd3, 32'h0041_0020, 32'h0000_0100, 32'hFFFF_FFD0, 32'h0000_0100));
    settle();
    set_reg(REG_SECTIONS_IN_USE, 32'd4);
    set_reg(REG_IMAGE_LENGTH, 32'h0001_0000);
    foreach (short_len_probes[i]) send_signature(short_len_probes[i], SEQ_GOOD, 1'b0);
    settle();
    set_reg(REG_IMAGE_LENGTH, 32'hFFFF_FFFF);
    foreach (full_len_probes[i]) send_signature(full_len_probes[i], SEQ_GOOD, 1'b0);
    settle();
    // count above the table size walks all of it
    set_reg(REG_SECTIONS_IN_USE, 32'd127);
    send_signature(32'h0041_0040, SEQ_GOOD, 1'b0);
    send_signature(pick_string_address(), SEQ_GOOD, 1'b1);
    settle();
    set_reg(REG_SECTIONS_IN_USE, 32'd1);
    send_signature(32'h0040_1000, SEQ_GOOD, 1'b0);
    send_signature(32'h0040_1800, SEQ_GOOD, 1'b0);
  endtask

  // Blocks of mixed traffic, each under fresh register values. Mostly whole
  // instruction runs with random operands; the rest broken runs, noise and
  // section reloads. The tail runs with no idling on either side.
  task automatic test_random_traffic();
    int  items;
    int  block_n;
    int  r;
    int  cnt;
    bit  quiet;
    items = 0;
    while (items < RANDOM_ITEMS) begin
      quiet    = (items >= RANDOM_ITEMS - 250);
      settle();
      gaps_on  = !quiet && $urandom_range(0, 3) != 0;
      stall_on = !quiet && $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 5))
        0:       cnt = 0;
        1:       cnt = 1;
        2:       cnt = wcss_pkg::MAX_SECTIONS;
        3:       cnt = $urandom_range(wcss_pkg::MAX_SECTIONS + 1, 127);
        default: cnt = $urandom_range(1, wcss_pkg::MAX_SECTIONS);
      endcase
      set_reg(REG_SECTIONS_IN_USE, ($urandom & 32'hFFFF_FF80) | 32'(cnt));
      case ($urandom_range(0, 5))
        0:       set_reg(REG_IMAGE_LENGTH, 32'd0);
        1:       set_reg(REG_IMAGE_LENGTH, 32'hFFFF_FFFF);
        2:       set_reg(REG_IMAGE_LENGTH, $urandom);
        default: set_reg(REG_IMAGE_LENGTH, $urandom_range(32'h100, 32'h4_0000));
      endcase
      block_n = 0;
      while (block_n < BLOCK_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          send_signature(pick_string_address(), SEQ_GOOD, $urandom_range(0, 7) == 0);
          block_n += wcss_pkg::PATTERN_BYTES;
        end else if (r < 70) begin
          send_signature(pick_string_address(), seq_kind_t'($urandom_range(1, 3)), 1'b0);
          block_n += wcss_pkg::PATTERN_BYTES;
        end else if (r < 78) begin
          cnt = $urandom_range(0, 127);
          load_random_slot(7'(cnt));
          if (cnt < wcss_pkg::MAX_SECTIONS) block_n += 1;
        end else begin
          cnt = $urandom_range(1, 20);
          send_noise(cnt);
          block_n += cnt;
        end
      end
      items += block_n;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    in_tlast       = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    sec_count_reg  = '0;
    image_len_reg  = '0;
    stream_pos     = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    gaps_on        = 1'b1;
    stall_on       = 1'b1;
    for (int k = 0; k < wcss_pkg::WINDOW_DEPTH; k++) win_hist[k] = 8'd0;
    for (int i = 0; i < wcss_pkg::MAX_SECTIONS; i++) begin
      sec_vbase[i] = '0;
      sec_vsize[i] = '0;
      sec_roff[i]  = '0;
      sec_rsize[i] = '0;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_registers();
    test_unmapped_candidates();
    test_section_table();
    test_mapping();
    test_random_traffic();

    // drain everything still in flight, then the walk time once more
    settle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/wcss_pkg.sv
rtl/wcss_ram.sv
rtl/wcss_alu.sv
rtl/wcss_win.sv
rtl/wildcard_code_signature_scanner.sv
tb/wildcard_code_signature_scanner_tb.sv
